// File: src/lri_pkg.sv
`default_nettype none

package lri_pkg;

    // Field and register widths.
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 16;
    localparam int INC_W       = 17;
    localparam int ALIAS_W     = 17;
    localparam int RATE_W      = 18;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_INC = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ALIAS     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_RATE      = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [INC_W-1:0]   PHASE_INC_RST = 17'h10000;
    localparam logic [ALIAS_W-1:0] ALIAS_RST     = 17'd0;
    localparam logic [RATE_W-1:0]  RATE_RST      = 18'd48000;

    // Unity in Q1.16 and the aliasing damping band in hertz.
    localparam logic [FRAC_W:0]    ONE_Q     = 17'h10000;
    localparam logic [RATE_W-1:0]  RATE_LO   = 18'd4000;
    localparam logic [RATE_W-1:0]  RATE_SPAN = 18'd16000;

    // Iterative divider geometry.
    localparam int DIV_NUM_W = 33;
    localparam int DIV_DEN_W = 18;
    localparam int DIV_QUO_W = 17;
    localparam int DIV_CNT_W = 5;

    // Decay table: exp(-5k/depth) in Q1.16, entry zero is exactly one.
    localparam int EXP_DEPTH = 256;
    localparam int EXP_IDX_W = 8;
    localparam int EXP_W     = 17;

    typedef logic [EXP_DEPTH-1:0][EXP_W-1:0] exp_tab_t;

    // Builds the decay table from a Taylor series of the per-entry ratio in
    // Q0.32 followed by repeated products. Evaluated at elaboration only.
    function automatic exp_tab_t build_exp_tab();
        exp_tab_t    tab;
        logic [63:0] d;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] r;
        logic [63:0] cur;
        logic [63:0] rv;
        d    = (64'd5 << 32) / 64'(EXP_DEPTH);
        term = 64'd1 << 32;
        pos  = 64'd1 << 32;
        neg  = 64'd0;
        for (int n = 1; n < 40; n++) begin
            term = ((term * d) >> 32) / 64'(n);
            if ((n % 2) == 1) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        r   = pos - neg;
        cur = 64'd1 << 32;
        for (int k = 0; k < EXP_DEPTH; k++) begin
            rv     = ((cur >> 1) + (64'd1 << 14)) >> 15;
            tab[k] = rv[EXP_W-1:0];
            cur    = (cur * r) >> 32;
        end
        return tab;
    endfunction

    localparam exp_tab_t EXP_TAB = build_exp_tab();

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic cfg_we;
        logic in_load;
        logic div_start;
        logic shift_ld;
        logic scale_ld;
        logic mul1_en;
        logic idx_en;
        logic coef_en;
        logic mul2_en;
        logic out_ld;
    } lri_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
    } lri_status_t;

endpackage

`default_nettype wire

// File: src/lofi_resampler_interpolator_unit.sv
// Lo-fi resampler interpolator.
// Input channel (s_): one transfer per output tick, carrying the next unconsumed
// source sample and an end-of-block mark. Result channel (m_): one transfer per
// input transfer, carrying the interpolated sample, whether the offered sample
// was consumed (if not, the host offers it again next tick) and the block mark.
// Configuration channel (cfg_): writes phase increment (index 0), aliasing
// amount (index 1) and emulated input rate (index 2); other indexes are ignored.
// Sequence: an item's input transfer loads the input registers; the first
// multiply, index, coefficient (table read) and second multiply states follow,
// and the output state loads the result register. The block takes no new item
// until the previous one has left the output state.
// After reset and after every configuration write, the damping shift is
// reloaded and a serial divider recomputes the damped aliasing coefficients;
// s_ready stays low meanwhile.
// Reset loads the default registers, sets the phase to one half and clears the
// held samples. When the receiver stalls, the result waits in the output
// register; the next item is accepted and computed, and waits in its last
// stage until the output register is free.

`default_nettype none

module lofi_resampler_interpolator_unit
    import lri_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic signed [SAMPLE_W-1:0]  s_next_sample,
    input  wire logic                        s_end_of_block,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic signed [SAMPLE_W-1:0]       m_out_sample,
    output logic                             m_took_sample,
    output logic                             m_last_of_block,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]       cfg_wdata
);

    lri_cmd_t    cmd;
    lri_status_t status;

    // Sequencer for coefficient refresh and item processing.
    lri_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // Arithmetic, state and result register.
    lri_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_next_sample  (s_next_sample),
        .s_end_of_block (s_end_of_block),
        .out_sample     (m_out_sample),
        .took_sample    (m_took_sample),
        .last_of_block  (m_last_of_block)
    );

endmodule

`default_nettype wire

// File: src/lri_div.sv
`default_nettype none

module lri_div
    import lri_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output logic                      done,
    output logic [DIV_QUO_W-1:0]      quo
);

    localparam logic [DIV_CNT_W-1:0] CNT_LAST = DIV_CNT_W'(DIV_QUO_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_DEN_W-1:0] rem_reg;
    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_QUO_W-1:0] low_reg;

    logic [DIV_DEN_W:0]   trial;
    logic                 fits;
    logic [DIV_DEN_W:0]   diff;

    // One restoring step: bring down the next numerator bit and try the divisor.
    assign trial = {rem_reg, low_reg[DIV_QUO_W-1]};
    assign fits  = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    // Control: step counter and completion pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and the numerator word that turns into the quotient.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= DIV_DEN_W'(num[DIV_NUM_W-1:DIV_QUO_W]);
            low_reg <= num[DIV_QUO_W-1:0];
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg <= fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
            low_reg <= {low_reg[DIV_QUO_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = low_reg;

endmodule

`default_nettype wire

// File: src/lri_ctrl.sv
`default_nettype none

module lri_ctrl
    import lri_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_valid,
    output logic       s_ready,
    output logic       m_valid,
    input  wire logic  m_ready,
    input  wire logic  cfg_valid,
    output logic       cfg_ready,
    output lri_cmd_t   cmd,
    input  lri_status_t status
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SHIFT_LD  = 4'd1;
    localparam logic [3:0] ST_SCALE_LD  = 4'd2;
    localparam logic [3:0] ST_SCALE_RUN = 4'd3;
    localparam logic [3:0] ST_MUL1      = 4'd4;
    localparam logic [3:0] ST_IDX       = 4'd5;
    localparam logic [3:0] ST_COEF      = 4'd6;
    localparam logic [3:0] ST_MUL2      = 4'd7;
    localparam logic [3:0] ST_OUT       = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    // The result register can take a new value when empty or being drained.
    assign out_free = !out_valid_reg || m_ready;

    // Handshakes: configuration wins over a pending item in the idle state.
    assign cfg_ready = (state_reg == ST_IDLE);
    assign s_ready   = (state_reg == ST_IDLE) && !cfg_valid;
    assign m_valid   = out_valid_reg;

    // Sequencer: derived-coefficient refresh after reset and writes, then items.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    cmd.cfg_we = 1'b1;
                    state_next = ST_SHIFT_LD;
                end else if (s_valid) begin
                    cmd.in_load = 1'b1;
                    state_next  = ST_MUL1;
                end
            end
            ST_SHIFT_LD: begin
                cmd.shift_ld = 1'b1;
                state_next   = ST_SCALE_LD;
            end
            ST_SCALE_LD: begin
                cmd.div_start = 1'b1;
                state_next    = ST_SCALE_RUN;
            end
            ST_SCALE_RUN: begin
                if (status.div_done) begin
                    cmd.scale_ld = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_MUL1: begin
                cmd.mul1_en = 1'b1;
                state_next  = ST_IDX;
            end
            ST_IDX: begin
                cmd.idx_en = 1'b1;
                state_next = ST_COEF;
            end
            ST_COEF: begin
                cmd.coef_en = 1'b1;
                state_next  = ST_MUL2;
            end
            ST_MUL2: begin
                cmd.mul2_en = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.out_ld = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid flag: set on load, cleared by a transfer.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_ld) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_SHIFT_LD;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: src/lri_dp.sv
`default_nettype none

module lri_dp
    import lri_pkg::*;
(
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  lri_cmd_t                         cmd,
    output lri_status_t                      status,
    input  wire logic [CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]       cfg_wdata,
    input  wire logic signed [SAMPLE_W-1:0]  s_next_sample,
    input  wire logic                        s_end_of_block,
    output logic signed [SAMPLE_W-1:0]       out_sample,
    output logic                             took_sample,
    output logic                             last_of_block
);

    localparam logic [26:0]  RECIP5   = 27'd52429;
    localparam logic [23:0]  SHIFT_RECIP = 24'd8589935;
    localparam logic [8:0]   IDX_MAX  = 9'(EXP_DEPTH - 1);
    localparam logic signed [23:0] SAT_HI = 24'sd32767;
    localparam logic signed [23:0] SAT_LO = -24'sd32768;

    // Round half away from zero of a Q.16 value to an integer.
    function automatic logic signed [23:0] rnd_q16(input logic signed [39:0] v);
        logic signed [39:0] s;
        s = v + $signed({24'd0, 16'h8000}) - $signed({39'd0, v[39]});
        return s[39:16];
    endfunction

    // Configuration registers.
    logic [INC_W-1:0]   inc_reg;
    logic [ALIAS_W-1:0] alias_reg;
    logic [RATE_W-1:0]  rate_reg;

    // Coefficients derived from the configuration.
    logic [FRAC_W:0]    shift_reg;
    logic               mode_reg;
    logic [FRAC_W-1:0]  step_reg;
    logic [18:0]        c_reg;

    // Interpolator state.
    logic [FRAC_W-1:0]          phase_reg;
    logic signed [SAMPLE_W-1:0] older_reg;
    logic signed [SAMPLE_W-1:0] newer_reg;

    // Per-item registers.
    logic signed [SAMPLE_W-1:0] in_sample_reg;
    logic                       in_eob_reg;
    logic signed [36:0]         prod1_reg;
    logic signed [16:0]         lerp_reg;
    logic [EXP_IDX_W-1:0]       idx_reg;
    logic signed [17:0]         coef_reg;
    logic signed [35:0]         prod2_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       took_reg;
    logic                       last_reg;

    logic [ALIAS_W-1:0]   alias_sat;
    logic [INC_W-1:0]     inc_sat;
    logic [RATE_W-1:0]    rate_diff;
    logic                 shift_hi;
    logic [37:0]          shift_prod;
    logic [FRAC_W:0]      shift_q;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_QUO_W-1:0] div_quo;
    logic [15:0]          scale_excess;
    logic [18:0]          c_next;

    logic signed [16:0]   ab_diff;
    logic signed [19:0]   mul1_a;
    logic signed [16:0]   mul1_b;
    logic signed [36:0]   mul1_p;
    logic signed [39:0]   lerp_sum;
    logic signed [23:0]   lerp_rnd;
    logic [26:0]          idx_prod;
    logic [8:0]           idx_q;
    logic [EXP_IDX_W-1:0] idx_next;
    logic signed [17:0]   coef_next;
    logic signed [17:0]   mul2_a;
    logic signed [17:0]   mul2_b;
    logic signed [35:0]   mul2_p;
    logic signed [39:0]   out_sum;
    logic signed [23:0]   y_rnd;
    logic signed [SAMPLE_W-1:0] y_sat;
    logic [FRAC_W:0]      phase_sum;

    // Saturated register views and the damping input.
    assign alias_sat = (alias_reg > ALIAS_W'(ONE_Q)) ? ALIAS_W'(ONE_Q) : alias_reg;
    assign inc_sat   = (inc_reg > INC_W'(ONE_Q)) ? INC_W'(ONE_Q) : inc_reg;
    assign rate_diff = (rate_reg > RATE_LO) ? (rate_reg - RATE_LO) : '0;
    assign shift_hi  = rate_diff >= RATE_SPAN;

    // Damping shift: the rate excess times 512/125 by reciprocal multiplication,
    // exact for every excess below the top of the band.
    assign shift_prod = 38'(rate_diff[13:0]) * SHIFT_RECIP;
    assign shift_q    = shift_prod[37:21];

    // Divider operands: aliasing amount over one plus the damping shift.
    assign div_num = {alias_sat, {FRAC_W{1'b0}}};
    assign div_den = {1'b0, shift_reg} + DIV_DEN_W'(ONE_Q);

    lri_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign status.div_done = div_done;

    // Decay slope: (scaled - one half) * 10, as shift-and-add.
    assign scale_excess = div_quo[15:0] - 16'h8000;
    assign c_next       = {scale_excess, 3'd0} + {2'd0, scale_excess, 1'd0};

    // First product: sample difference times phase, or phase times decay slope.
    assign ab_diff = {newer_reg[SAMPLE_W-1], newer_reg} - {older_reg[SAMPLE_W-1], older_reg};
    assign mul1_a  = mode_reg ? $signed({1'b0, c_reg}) : {{3{ab_diff[16]}}, ab_diff};
    assign mul1_b  = $signed({1'b0, phase_reg});
    assign mul1_p  = mul1_a * mul1_b;

    // Linear interpolation result, or the table index as (t >> 8) / 5.
    assign lerp_sum = $signed({{8{older_reg[SAMPLE_W-1]}}, older_reg, 16'd0})
                    + {{3{prod1_reg[36]}}, prod1_reg};
    assign lerp_rnd = rnd_q16(lerp_sum);
    assign idx_prod = 27'(prod1_reg[34:24]) * RECIP5;
    assign idx_q    = idx_prod[26:18];
    assign idx_next = (idx_q > IDX_MAX) ? EXP_IDX_W'(IDX_MAX) : idx_q[EXP_IDX_W-1:0];

    // Second operand: the decay factor, or the hold-minus-lerp difference.
    assign coef_next = mode_reg ? $signed({1'b0, EXP_TAB[idx_reg]})
                                : ({{2{older_reg[SAMPLE_W-1]}}, older_reg}
                                   - {lerp_reg[16], lerp_reg});

    assign mul2_a = mode_reg ? {{2{older_reg[SAMPLE_W-1]}}, older_reg} : coef_reg;
    assign mul2_b = mode_reg ? coef_reg : $signed({2'd0, step_reg});
    assign mul2_p = mul2_a * mul2_b;

    // Final rounding and saturation.
    assign out_sum = mode_reg
                   ? {{4{prod2_reg[35]}}, prod2_reg}
                   : ($signed({{7{lerp_reg[16]}}, lerp_reg, 16'd0})
                      + {{4{prod2_reg[35]}}, prod2_reg});
    assign y_rnd = rnd_q16(out_sum);

    always_comb begin
        priority if (y_rnd > SAT_HI) begin
            y_sat = SAT_HI[SAMPLE_W-1:0];
        end else if (y_rnd < SAT_LO) begin
            y_sat = SAT_LO[SAMPLE_W-1:0];
        end else begin
            y_sat = y_rnd[SAMPLE_W-1:0];
        end
    end

    assign phase_sum = {1'b0, phase_reg} + inc_sat;

    // Configuration writes and derived coefficients.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inc_reg   <= PHASE_INC_RST;
            alias_reg <= ALIAS_RST;
            rate_reg  <= RATE_RST;
        end else if (cmd.cfg_we) begin
            unique case (cfg_addr)
                REG_PHASE_INC: inc_reg   <= cfg_wdata[INC_W-1:0];
                REG_ALIAS:     alias_reg <= cfg_wdata[ALIAS_W-1:0];
                REG_RATE:      rate_reg  <= cfg_wdata[RATE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.shift_ld) begin
            shift_reg <= shift_hi ? ONE_Q : shift_q;
        end
        if (cmd.scale_ld) begin
            mode_reg <= div_quo[16] | div_quo[15];
            step_reg <= {div_quo[14:0], 1'b0};
            c_reg    <= c_next;
        end
    end

    // Phase and the held sample pair; updated when the result is loaded.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= FRAC_W'(ONE_Q >> 1);
            older_reg <= '0;
            newer_reg <= '0;
        end else if (cmd.out_ld) begin
            phase_reg <= phase_sum[FRAC_W-1:0];
            if (phase_sum[FRAC_W]) begin
                older_reg <= newer_reg;
                newer_reg <= in_sample_reg;
            end
        end
    end

    // Item pipeline registers and the result register.
    always_ff @(posedge aclk) begin
        if (cmd.in_load) begin
            in_sample_reg <= s_next_sample;
            in_eob_reg    <= s_end_of_block;
        end
        if (cmd.mul1_en) begin
            prod1_reg <= mul1_p;
        end
        if (cmd.idx_en) begin
            lerp_reg <= lerp_rnd[16:0];
            idx_reg  <= idx_next;
        end
        if (cmd.coef_en) begin
            coef_reg <= coef_next;
        end
        if (cmd.mul2_en) begin
            prod2_reg <= mul2_p;
        end
        if (cmd.out_ld) begin
            out_sample_reg <= y_sat;
            took_reg       <= phase_sum[FRAC_W];
            last_reg       <= in_eob_reg;
        end
    end

    assign out_sample    = out_sample_reg;
    assign took_sample   = took_reg;
    assign last_of_block = last_reg;

endmodule

`default_nettype wire
